[design/vbfe_pkg.sv]
// Shared types, constants and the face corner table for the voxel face extractor.
package vbfe_pkg;

	localparam int MAX_DIM_DEF = 32;
	localparam int CRD_W       = 5;
	localparam int DIM_W       = 6;
	localparam int PT_W        = 16;
	localparam int FACE_W      = 3;
	localparam int NFACE       = 6;
	localparam int CFG_IDX_W   = 2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

	localparam int FACE_XM = 0;
	localparam int FACE_XP = 1;
	localparam int FACE_YM = 2;
	localparam int FACE_YP = 3;
	localparam int FACE_ZM = 4;
	localparam int FACE_ZP = 5;

	// Voxel corner code: bit0 +x, bit1 +y, bit2 +z.
	localparam logic [2:0] FACE_CORNER [NFACE][4] = '{
		'{3'd0, 3'd4, 3'd6, 3'd2},
		'{3'd1, 3'd3, 3'd7, 3'd5},
		'{3'd0, 3'd1, 3'd5, 3'd4},
		'{3'd2, 3'd6, 3'd7, 3'd3},
		'{3'd0, 3'd2, 3'd3, 3'd1},
		'{3'd4, 3'd5, 3'd7, 3'd6}
	};

	// Occupancy rows read for a query: the centre column and its four side columns.
	typedef enum logic [2:0] {
		ROW_CTR = 3'd0,
		ROW_XM  = 3'd1,
		ROW_XP  = 3'd2,
		ROW_YM  = 3'd3,
		ROW_YP  = 3'd4
	} row_sel_t;

	typedef struct packed {
		logic             func;
		logic [CRD_W-1:0] vox_x;
		logic [CRD_W-1:0] vox_y;
		logic [CRD_W-1:0] vox_z;
		logic             occupied;
	} in_item_t;

	typedef struct packed {
		logic              has_face;
		logic [FACE_W-1:0] face;
		logic [PT_W-1:0]   corner_a;
		logic [PT_W-1:0]   corner_b;
		logic [PT_W-1:0]   corner_c;
		logic [PT_W-1:0]   corner_d;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [DIM_W-1:0]     wdata;
	} cfg_item_t;

	typedef struct packed {
		logic     load;
		logic     clr;
		logic     rd_en;
		row_sel_t rd_sel;
		logic     wr;
		logic     ar_a;
		logic     ar_b;
		logic     ar_c;
		logic     mask;
		logic     emit;
	} vbfe_cmd_t;

	typedef struct packed {
		logic func;
		logic clr_last;
		logic out_free;
		logic emit_last;
	} vbfe_sts_t;

endpackage

[design/vbfe_chan_if.sv]
// Valid/ready channel carrying one payload item.
interface vbfe_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/vbfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vbfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/vbfe_ctrl.sv]
// Sequencer for clearing, write read-modify-write and query steps.
module vbfe_ctrl
	import vbfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vbfe_sts_t sts,
	output vbfe_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CRD,
		S_WWR,
		S_QRD,
		S_QCAP,
		S_MASK,
		S_EMIT
	} state_t;

	state_t   state_q;
	row_sel_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			row_q   <= ROW_CTR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_CRD;
				end
				S_CRD: begin
					if (sts.func == FUNC_WRITE) begin
						state_q <= S_WWR;
					end else begin
						state_q <= S_QRD;
						row_q   <= ROW_XM;
					end
				end
				S_WWR: state_q <= S_IDLE;
				S_QRD: begin
					row_q <= row_sel_t'(row_q + 3'd1);
					if (row_q == ROW_YP) state_q <= S_QCAP;
				end
				S_QCAP: state_q <= S_MASK;
				S_MASK: state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free && sts.emit_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.rd_sel = ROW_CTR;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE:  cmd.load = in_valid;
			S_CRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ROW_CTR;
				cmd.ar_a   = 1'b1;
			end
			S_WWR: cmd.wr = 1'b1;
			S_QRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = row_q;
				cmd.ar_b   = (row_q == ROW_XM);
				cmd.ar_c   = (row_q == ROW_XP);
			end
			S_MASK: cmd.mask = 1'b1;
			S_EMIT: cmd.emit = sts.out_free;
			default: ;
		endcase
	end
endmodule

[design/vbfe_dp.sv]
// Datapath: dimension registers, occupancy store, neighbour flags, corner arithmetic.
module vbfe_dp
	import vbfe_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  vbfe_cmd_t cmd,
	output vbfe_sts_t sts,
	input  in_item_t  in_data,
	input  logic      cfg_we,
	input  cfg_item_t cfg_data,
	output logic      out_vld,
	output out_item_t out_data,
	input  logic      out_rdy
);
	localparam int CW      = $clog2(MAX_DIM);
	localparam int AW      = 2 * CW;
	localparam int ROW_W   = 1 << CW;
	localparam int DEPTH   = 1 << AW;
	localparam int DW      = $clog2(MAX_DIM + 1);
	localparam int CMP_W   = (DW > CRD_W + 1) ? DW : CRD_W + 1;
	localparam int DIM_RST = (MAX_DIM < 32) ? MAX_DIM : 32;

	function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) clamp_dim = DW'(1);
		else if (int'(v) > MAX_DIM) clamp_dim = DW'(MAX_DIM);
		else clamp_dim = DW'(v);
	endfunction

	logic [DW-1:0] dim_x_q, dim_y_q, dim_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DW'(DIM_RST);
			dim_y_q <= DW'(DIM_RST);
			dim_z_q <= DW'(DIM_RST);
		end else if (cfg_we) begin
			case (cfg_data.idx)
				REG_DIM_X: dim_x_q <= clamp_dim(cfg_data.wdata);
				REG_DIM_Y: dim_y_q <= clamp_dim(cfg_data.wdata);
				REG_DIM_Z: dim_z_q <= clamp_dim(cfg_data.wdata);
				default: ;
			endcase
		end
	end

	// Item registers
	logic             func_q, occ_q;
	logic [CRD_W-1:0] x_q, y_q, z_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_data.func;
			occ_q  <= in_data.occupied;
			x_q    <= in_data.vox_x;
			y_q    <= in_data.vox_y;
			z_q    <= in_data.vox_z;
		end
	end

	// Grid bounds of the voxel and its neighbours
	logic [CMP_W-1:0] xe, ye, ze;
	logic             in_grid, xm_ok, xp_ok, ym_ok, yp_ok, zm_ok, zp_ok;

	assign xe      = CMP_W'(x_q);
	assign ye      = CMP_W'(y_q);
	assign ze      = CMP_W'(z_q);
	assign in_grid = (xe < CMP_W'(dim_x_q)) && (ye < CMP_W'(dim_y_q)) &&
	                 (ze < CMP_W'(dim_z_q));
	assign xm_ok   = (x_q != '0);
	assign ym_ok   = (y_q != '0);
	assign zm_ok   = (z_q != '0);
	assign xp_ok   = (xe + CMP_W'(1)) < CMP_W'(dim_x_q);
	assign yp_ok   = (ye + CMP_W'(1)) < CMP_W'(dim_y_q);
	assign zp_ok   = (ze + CMP_W'(1)) < CMP_W'(dim_z_q);

	logic [CW-1:0] xi, yi, zi, zm, zp;

	assign xi = CW'(x_q);
	assign yi = CW'(y_q);
	assign zi = CW'(z_q);
	assign zm = zi - CW'(1);
	assign zp = zi + CW'(1);

	// Occupancy store: one row of z bits per (x, y) column
	logic [AW-1:0]    clr_q, raddr, waddr;
	logic [ROW_W-1:0] rdata, wrow, wdata;
	logic             we;
	logic             rd_en_s1;
	row_sel_t         rd_sel_s1;

	always_comb begin
		case (cmd.rd_sel)
			ROW_CTR: raddr = {xi, yi};
			ROW_XM:  raddr = {xi - CW'(1), yi};
			ROW_XP:  raddr = {xi + CW'(1), yi};
			ROW_YM:  raddr = {xi, yi - CW'(1)};
			ROW_YP:  raddr = {xi, yi + CW'(1)};
			default: raddr = {xi, yi};
		endcase
	end

	always_comb begin
		wrow     = rdata;
		wrow[zi] = occ_q;
	end

	assign we    = cmd.clr || (cmd.wr && in_grid);
	assign waddr = cmd.clr ? clr_q : {xi, yi};
	assign wdata = cmd.clr ? '0 : wrow;

	vbfe_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			rd_en_s1  <= 1'b0;
			rd_sel_s1 <= ROW_CTR;
		end else begin
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			rd_en_s1  <= cmd.rd_en;
			rd_sel_s1 <= cmd.rd_sel;
		end
	end

	// Capture centre and neighbour occupancy as rows return
	logic             ctr_full_q;
	logic [NFACE-1:0] nb_q;

	always_ff @(posedge clk) begin
		if (rd_en_s1) begin
			case (rd_sel_s1)
				ROW_CTR: begin
					ctr_full_q    <= in_grid && rdata[zi];
					nb_q[FACE_ZM] <= zm_ok && rdata[zm];
					nb_q[FACE_ZP] <= zp_ok && rdata[zp];
				end
				ROW_XM:  nb_q[FACE_XM] <= xm_ok && rdata[zi];
				ROW_XP:  nb_q[FACE_XP] <= xp_ok && rdata[zi];
				ROW_YM:  nb_q[FACE_YM] <= ym_ok && rdata[zi];
				ROW_YP:  nb_q[FACE_YP] <= yp_ok && rdata[zi];
				default: ;
			endcase
		end
	end

	// Grid point index of corner (0,0,0): x*myz + y*mz + z, modulo 2^16
	logic [PT_W-1:0] mz, myz_q, ym_q, xm_q, base_q;

	assign mz = PT_W'(dim_z_q) + PT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.ar_a) begin
			myz_q <= PT_W'((PT_W'(dim_y_q) + PT_W'(1)) * mz);
			ym_q  <= PT_W'(PT_W'(y_q) * mz);
		end
		if (cmd.ar_b) xm_q <= PT_W'(PT_W'(x_q) * myz_q);
		if (cmd.ar_c) base_q <= xm_q + ym_q + PT_W'(z_q);
	end

	function automatic logic [PT_W-1:0] corner_pt(input logic [2:0] c);
		corner_pt = base_q + (c[0] ? myz_q : '0) + (c[1] ? mz : '0) + PT_W'(c[2]);
	endfunction

	// Exposed faces still to send, lowest first
	logic [NFACE-1:0]  rem_q, rem_clr;
	logic [FACE_W-1:0] nf;
	out_item_t         res, out_q;
	logic              out_vld_q;

	always_comb begin
		nf = '0;
		for (int i = NFACE - 1; i >= 0; i--) begin
			if (rem_q[i]) nf = FACE_W'(i);
		end
		rem_clr = rem_q & ~(NFACE'(1) << nf);
	end

	always_comb begin
		res = '0;
		if (rem_q != '0) begin
			res.has_face = 1'b1;
			res.face     = nf;
			res.corner_a = corner_pt(FACE_CORNER[nf][0]);
			res.corner_b = corner_pt(FACE_CORNER[nf][1]);
			res.corner_c = corner_pt(FACE_CORNER[nf][2]);
			res.corner_d = corner_pt(FACE_CORNER[nf][3]);
		end
		res.last = (rem_clr == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.mask) rem_q <= ctr_full_q ? ~nb_q : '0;
		else if (cmd.emit) rem_q <= rem_clr;
		if (cmd.emit) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_vld       = out_vld_q;
	assign out_data      = out_q;
	assign sts.func      = func_q;
	assign sts.clr_last  = &clr_q;
	assign sts.out_free  = !out_vld_q || out_rdy;
	assign sts.emit_last = (rem_clr == '0);
endmodule

[design/voxel_boundary_face_extract.sv]
// Voxel boundary face extractor: occupancy store with exposed-face query.
// Write item: read row, write row back, then the next item can be accepted.
// Query item: five row reads of the store (one read port), then results enter the output
// register one a cycle while the output is not stalled.
// At most one item is in work at a time. Reset: asynchronous, active low, then a clearing
// pass of one row per cycle over all 1024 rows at MAX_DIM 32, with no item taken meanwhile.
module voxel_boundary_face_extract
	import vbfe_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	vbfe_chan_if.sink          in_ch,
	vbfe_chan_if.source        out_ch,
	vbfe_chan_if.sink          cfg_ch
);
	vbfe_cmd_t cmd;
	vbfe_sts_t sts;
	logic      in_rdy;

	// Sequencer: clears the store after reset, then walks each item through its steps
	vbfe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_rdy),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: dims, occupancy rows, neighbour flags, corner indices, output register.
	// The output register frees the sequencer to take the next item while the last
	// result of a query still waits downstream.
	vbfe_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (in_ch.data),
		.cfg_we  (cfg_ch.valid),
		.cfg_data(cfg_ch.data),
		.out_vld (out_ch.valid),
		.out_data(out_ch.data),
		.out_rdy (out_ch.ready)
	);

	assign in_ch.ready  = in_rdy;
	// Dimension registers take a write in any cycle; writes beyond the list are dropped
	assign cfg_ch.ready = 1'b1;
endmodule

[design/vbfe_chk.sv]
// Port-level checks on the voxel face extractor, bound to the top level.
module vbfe_chk
	import vbfe_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed or dropped while stalled");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_face |-> out_data.last && out_data.face == '0 &&
		out_data.corner_a == '0 && out_data.corner_b == '0 &&
		out_data.corner_c == '0 && out_data.corner_d == '0)
		else $error("faceless result is not a lone zero result");

	a_no_take_mid_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("item taken while a query still has results to send");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken in two consecutive cycles");
endmodule

bind voxel_boundary_face_extract vbfe_chk u_vbfe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);
